@@ src/tbt_pkg.sv @@
// Shared types, constants and saturation helpers for the three-beacon triangulation block.
package tbt_pkg;

    localparam int ANG_W   = 30;
    localparam int ROT_W   = 32;
    localparam int COT_W   = 32;
    localparam int MID_W   = 31;
    localparam int OFF_W   = 42;
    localparam int WIDE_W  = 80;
    localparam int TAB_LEN = 24;
    localparam int CFG_IDX_W = 3;

    localparam longint MID_LIM = 64'sd1073741823;
    localparam longint COT_LIM = 64'sd2147483647;
    localparam longint OFF_LIM = 64'sd1099511627776;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [COT_W-1:0]  t_cot;
    typedef logic signed [MID_W-1:0]  t_mid;
    typedef logic signed [OFF_W-1:0]  t_off;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_ang ANG_PI      = 30'sd52707179;
    localparam t_ang ANG_HALF_PI = 30'sd26353589;
    localparam logic signed [ROT_W-1:0] ROT_START = 32'sd268435456;

    localparam t_ang ATAN_TAB [TAB_LEN] = '{
        30'sd13176795, 30'sd7778716, 30'sd4110060, 30'sd2086331,
        30'sd1047214,  30'sd524117,  30'sd262123,  30'sd131069,
        30'sd65536,    30'sd32768,   30'sd16384,   30'sd8192,
        30'sd4096,     30'sd2048,    30'sd1024,    30'sd512,
        30'sd256,      30'sd128,     30'sd64,      30'sd32,
        30'sd16,       30'sd8,       30'sd4,       30'sd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAX = 3'd0,
        CFG_BAY = 3'd1,
        CFG_BBX = 3'd2,
        CFG_BBY = 3'd3,
        CFG_BCX = 3'd4,
        CFG_BCY = 3'd5
    } t_cfg_idx;

    // Cotangent of one bearing difference, as it leaves a lane
    typedef struct packed {
        logic vld;
        logic bad;
        t_cot cot;
    } t_cot_res;

    function automatic t_mid sat_mid(input t_wide v);
        t_mid r;
        if (v > MID_LIM) begin
            r = MID_W'(MID_LIM);
        end else if (v < -MID_LIM) begin
            r = MID_W'(-MID_LIM);
        end else begin
            r = MID_W'(v);
        end
        return r;
    endfunction

    function automatic t_cot sat_cot(input t_wide v);
        t_cot r;
        if (v > COT_LIM) begin
            r = COT_W'(COT_LIM);
        end else if (v < -COT_LIM) begin
            r = COT_W'(-COT_LIM);
        end else begin
            r = COT_W'(v);
        end
        return r;
    endfunction

    function automatic t_off sat_off(input t_wide v);
        t_off r;
        if (v > OFF_LIM) begin
            r = OFF_W'(OFF_LIM);
        end else if (v < -OFF_LIM) begin
            r = OFF_W'(-OFF_LIM);
        end else begin
            r = OFF_W'(v);
        end
        return r;
    endfunction

endpackage

@@ src/tbt_vcordic.sv @@
// Bearing lane: pipelined vectoring CORDIC giving atan2 of one sighted beacon.
module tbt_vcordic #(
    parameter int COORD_WIDTH  = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    output logic                          o_vld,
    output tbt_pkg::t_ang                 o_ang
);
    import tbt_pkg::*;

    localparam int VW = COORD_WIDTH + 14;

    logic signed [VW-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [VW-1:0] r_y    [0:CORDIC_STEPS];
    t_ang                 r_z    [0:CORDIC_STEPS];
    logic                 r_zero [0:CORDIC_STEPS];
    logic                 r_vld  [0:CORDIC_STEPS];

    logic signed [VW-1:0] n_x0, n_y0;
    t_ang                 n_z0;
    logic signed [VW-1:0] n_x [1:CORDIC_STEPS];
    logic signed [VW-1:0] n_y [1:CORDIC_STEPS];
    t_ang                 n_z [1:CORDIC_STEPS];

    // Scale, then fold the left half-plane onto the right one
    always_comb begin
        n_x0 = VW'(i_x) <<< 10;
        n_y0 = VW'(i_y) <<< 10;
        n_z0 = '0;
        if (n_x0 < 0) begin
            n_z0 = (i_y >= 0) ? ANG_PI : -ANG_PI;
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
    end

    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (r_y[i] < 0) begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - ATAN_TAB[i];
            end else begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_x[k+1]    <= n_x[k+1];
                r_y[k+1]    <= n_y[k+1];
                r_z[k+1]    <= n_z[k+1];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_vld = r_vld[CORDIC_STEPS];
    assign o_ang = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];

endmodule

@@ src/tbt_div.sv @@
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
module tbt_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_vld,
    output logic signed [NUM_W:0]   o_quo,
    output logic [SIDE_W-1:0]       o_side
);
    logic [DEN_W-1:0]  r_rem  [0:NUM_W-1];
    logic [NUM_W-1:0]  r_q    [0:NUM_W];
    logic [DEN_W-1:0]  r_d    [0:NUM_W];
    logic              r_neg  [0:NUM_W];
    logic              r_vld  [0:NUM_W];
    logic [SIDE_W-1:0] r_side [0:NUM_W];

    logic [DEN_W:0]    n_t   [0:NUM_W-1];
    logic              n_ge  [0:NUM_W-1];
    logic [DEN_W-1:0]  n_rem [0:NUM_W-1];
    logic [NUM_W-1:0]  n_num_mag;
    logic [DEN_W-1:0]  n_den_mag;

    assign n_num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign n_den_mag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    // Shift in the next dividend bit, subtract where it fits
    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            n_t[k]   = {r_rem[k], r_q[k][NUM_W-1]};
            n_ge[k]  = n_t[k] >= {1'b0, r_d[k]};
            n_rem[k] = n_ge[k] ? DEN_W'(n_t[k] - {1'b0, r_d[k]}) : DEN_W'(n_t[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < NUM_W; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
        if (i_en) begin
            r_rem[0]  <= '0;
            r_q[0]    <= n_num_mag;
            r_d[0]    <= n_den_mag;
            r_neg[0]  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_side[0] <= i_side;
            for (int k = 0; k < NUM_W; k++) begin
                if (k + 1 < NUM_W) begin
                    r_rem[k+1] <= n_rem[k];
                end
                r_q[k+1]    <= {r_q[k][NUM_W-2:0], n_ge[k]};
                r_d[k+1]    <= r_d[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_vld  = r_vld[NUM_W];
    assign o_side = r_side[NUM_W];
    assign o_quo  = r_neg[NUM_W] ? -$signed({1'b0, r_q[NUM_W]}) : $signed({1'b0, r_q[NUM_W]});

endmodule

@@ src/tbt_cot.sv @@
// Cotangent lane: reduces a bearing difference modulo pi and turns it into a Q.16 cotangent.
module tbt_cot #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  tbt_pkg::t_ang     i_from,
    input  tbt_pkg::t_ang     i_to,
    output tbt_pkg::t_cot_res o_res
);
    import tbt_pkg::*;

    localparam int DW    = ANG_W + 1;
    localparam int NUM_W = ROT_W + 16;

    logic signed [DW-1:0]    r_d   [0:CORDIC_STEPS];
    logic signed [ROT_W-1:0] r_x   [0:CORDIC_STEPS];
    logic signed [ROT_W-1:0] r_y   [0:CORDIC_STEPS];
    logic                    r_bad [0:CORDIC_STEPS];
    logic                    r_vld [0:CORDIC_STEPS];

    logic signed [DW-1:0]    n_d;
    logic signed [DW-1:0]    n_dn [1:CORDIC_STEPS];
    logic signed [ROT_W-1:0] n_x  [1:CORDIC_STEPS];
    logic signed [ROT_W-1:0] n_y  [1:CORDIC_STEPS];

    logic                    w_dvld;
    logic signed [NUM_W:0]   w_quo;
    logic                    w_dbad;

    // Bring the difference into (-pi/2, pi/2]
    always_comb begin
        n_d = DW'(i_to) - DW'(i_from);
        for (int k = 0; k < 4; k++) begin
            if (n_d > DW'(ANG_HALF_PI)) begin
                n_d = n_d - DW'(ANG_PI);
            end else if (n_d <= -DW'(ANG_HALF_PI)) begin
                n_d = n_d + DW'(ANG_PI);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (r_d[i] >= 0) begin
                n_x[i+1]  = r_x[i] - (r_y[i] >>> i);
                n_y[i+1]  = r_y[i] + (r_x[i] >>> i);
                n_dn[i+1] = r_d[i] - DW'(ATAN_TAB[i]);
            end else begin
                n_x[i+1]  = r_x[i] + (r_y[i] >>> i);
                n_y[i+1]  = r_y[i] - (r_x[i] >>> i);
                n_dn[i+1] = r_d[i] + DW'(ATAN_TAB[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
        if (i_en) begin
            r_d[0]   <= n_d;
            r_x[0]   <= ROT_START;
            r_y[0]   <= '0;
            r_bad[0] <= (n_d == '0);
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_d[k+1]   <= n_dn[k+1];
                r_x[k+1]   <= n_x[k+1];
                r_y[k+1]   <= n_y[k+1];
                r_bad[k+1] <= r_bad[k];
            end
        end
    end

    tbt_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (ROT_W),
        .SIDE_W (1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_vld[CORDIC_STEPS]),
        .i_num   ($signed({r_x[CORDIC_STEPS], 16'h0000})),
        .i_den   (r_y[CORDIC_STEPS]),
        .i_side  (r_bad[CORDIC_STEPS] || (r_y[CORDIC_STEPS] == '0)),
        .o_vld   (w_dvld),
        .o_quo   (w_quo),
        .o_side  (w_dbad)
    );

    assign o_res.vld = w_dvld;
    assign o_res.bad = w_dbad;
    assign o_res.cot = sat_cot(WIDE_W'(w_quo));

endmodule

@@ src/tbt_solve.sv @@
// Merge stage: combines the two lane cotangents with the beacon geometry into a position.
module tbt_solve #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  tbt_pkg::t_cot_res             i_c12,
    input  tbt_pkg::t_cot_res             i_c23,
    input  logic signed [COORD_WIDTH-1:0] i_bax,
    input  logic signed [COORD_WIDTH-1:0] i_bay,
    input  logic signed [COORD_WIDTH-1:0] i_bbx,
    input  logic signed [COORD_WIDTH-1:0] i_bby,
    input  logic signed [COORD_WIDTH-1:0] i_bcx,
    input  logic signed [COORD_WIDTH-1:0] i_bcy,
    output logic                          o_vld,
    output logic                          o_bad,
    output logic signed [COORD_WIDTH-1:0] o_rx,
    output logic signed [COORD_WIDTH-1:0] o_ry
);
    import tbt_pkg::*;

    localparam int C31_NUM_W = 65;
    localparam int C31_DEN_W = COT_W + 1;
    localparam int OFS_NUM_W = 2 * MID_W;
    localparam int DD_W      = 2 * MID_W + 1 - 12;
    localparam int SUM_W     = OFF_W + 2;
    localparam int SIDE_W    = 1 + 4 * MID_W;
    localparam logic signed [SUM_W-1:0] OUT_HI =
        SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] OUT_LO = -OUT_HI - SUM_W'(1);

    // Geometry follows beacon registers; user changes them only while idle, unchecked
    t_mid r_e1x, r_e1y, r_e3x, r_e3y;
    logic signed [MID_W:0]       r_sx, r_sy, r_ssx, r_ssy;
    logic signed [2*MID_W-1:0]   r_ga, r_gb, r_gc, r_gd;
    t_mid                        r_cr;
    logic signed [DD_W-1:0]      r_dot;

    always_ff @(posedge i_clk) begin
        r_e1x <= sat_mid(WIDE_W'(i_bax) - WIDE_W'(i_bbx));
        r_e1y <= sat_mid(WIDE_W'(i_bay) - WIDE_W'(i_bby));
        r_e3x <= sat_mid(WIDE_W'(i_bcx) - WIDE_W'(i_bbx));
        r_e3y <= sat_mid(WIDE_W'(i_bcy) - WIDE_W'(i_bby));
        r_sx  <= (MID_W+1)'(r_e3x) - (MID_W+1)'(r_e1x);
        r_sy  <= (MID_W+1)'(r_e3y) - (MID_W+1)'(r_e1y);
        r_ssx <= (MID_W+1)'(r_e3x) + (MID_W+1)'(r_e1x);
        r_ssy <= (MID_W+1)'(r_e3y) + (MID_W+1)'(r_e1y);
        r_ga  <= (2*MID_W)'(r_e1x) * (2*MID_W)'(r_e3y);
        r_gb  <= (2*MID_W)'(r_e3x) * (2*MID_W)'(r_e1y);
        r_gc  <= (2*MID_W)'(r_e1x) * (2*MID_W)'(r_e3x);
        r_gd  <= (2*MID_W)'(r_e1y) * (2*MID_W)'(r_e3y);
        r_cr  <= sat_mid((WIDE_W'(r_ga) - WIDE_W'(r_gb)) >>> 12);
        r_dot <= DD_W'((WIDE_W'(r_gc) + WIDE_W'(r_gd)) >>> 12);
    end

    // Stage 1: products and sum of the lane cotangents
    logic                    r1_vld, r1_bad;
    logic signed [63:0]      r1_prod;
    logic signed [COT_W:0]   r1_den;
    logic signed [62:0]      r1_m12y, r1_m12x, r1_m23y, r1_m23x;
    // Stage 2: numerator of the third cotangent, first two circle centres
    logic                    r2_vld, r2_bad;
    logic signed [C31_NUM_W-1:0] r2_num;
    logic signed [COT_W:0]   r2_den;
    t_mid                    r2_p12x, r2_p12y, r2_p23x, r2_p23y;
    // Third cotangent divider
    logic                    w3_vld;
    logic signed [C31_NUM_W:0] w3_quo;
    logic [SIDE_W-1:0]       w3_side;
    t_cot                    w3_c31;
    // Stage 3: products with the third cotangent
    logic                    r3_vld, r3_bad;
    logic signed [63:0]      r3_mx, r3_my;
    logic signed [62:0]      r3_mk;
    t_mid                    r3_p12x, r3_p12y, r3_p23x, r3_p23y;
    // Stage 4: third centre and k31
    logic                    r4_vld, r4_bad;
    t_mid                    r4_p31x, r4_p31y, r4_k31;
    t_mid                    r4_p12x, r4_p12y, r4_p23x, r4_p23y;
    // Stage 5: centre differences
    logic                    r5_vld, r5_bad;
    t_mid                    r5_dxa, r5_dya, r5_dyb, r5_dxb, r5_k31;
    // Stage 6: determinant and numerator products
    logic                    r6_vld, r6_bad;
    logic signed [2*MID_W-1:0] r6_pa, r6_pb, r6_nx, r6_ny;
    // Stage 7: determinant back to Q.12
    logic                    r7_vld, r7_bad;
    logic signed [DD_W-1:0]  r7_dd;
    logic signed [2*MID_W-1:0] r7_nx, r7_ny;
    logic signed [2*MID_W:0] n7_diff, n7_adj;
    // Offset dividers
    logic                    w8_vldx, w8_vldy, w8_badx, w8_bady;
    logic signed [OFS_NUM_W:0] w8_qx, w8_qy;
    logic signed [SUM_W-1:0] n8_sx, n8_sy;
    // Stage 8: result register
    logic                    r8_vld, r8_bad;
    logic signed [COORD_WIDTH-1:0] r8_rx, r8_ry;

    function automatic logic signed [COORD_WIDTH-1:0] out_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (v > OUT_HI) begin
            r = COORD_WIDTH'(OUT_HI);
        end else if (v < OUT_LO) begin
            r = COORD_WIDTH'(OUT_LO);
        end else begin
            r = COORD_WIDTH'(v);
        end
        return r;
    endfunction

    assign w3_c31  = sat_cot(WIDE_W'(w3_quo));
    assign n7_diff = (2*MID_W+1)'(r6_pa) - (2*MID_W+1)'(r6_pb);
    assign n7_adj  = (n7_diff < 0) ? n7_diff + (2*MID_W+1)'(4095) : n7_diff;
    assign n8_sx   = SUM_W'(i_bbx) + SUM_W'(sat_off(WIDE_W'(w8_qx)));
    assign n8_sy   = SUM_W'(i_bby) + SUM_W'(sat_off(WIDE_W'(w8_qy)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_c12.vld && i_c23.vld;
            r2_vld <= r1_vld;
            r3_vld <= w3_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= w8_vldx && w8_vldy;
        end
        if (i_en) begin
            r1_bad  <= i_c12.bad || i_c23.bad;
            r1_prod <= 64'(i_c12.cot) * 64'(i_c23.cot);
            r1_den  <= (COT_W+1)'(i_c12.cot) + (COT_W+1)'(i_c23.cot);
            r1_m12y <= 63'(i_c12.cot) * 63'(r_e1y);
            r1_m12x <= 63'(i_c12.cot) * 63'(r_e1x);
            r1_m23y <= 63'(i_c23.cot) * 63'(r_e3y);
            r1_m23x <= 63'(i_c23.cot) * 63'(r_e3x);

            r2_bad  <= r1_bad || (r1_den == '0);
            r2_num  <= C31_NUM_W'(65'sd4294967296) - C31_NUM_W'(r1_prod);
            r2_den  <= r1_den;
            r2_p12x <= sat_mid(WIDE_W'(r_e1x) + (WIDE_W'(r1_m12y) >>> 16));
            r2_p12y <= sat_mid(WIDE_W'(r_e1y) - (WIDE_W'(r1_m12x) >>> 16));
            r2_p23x <= sat_mid(WIDE_W'(r_e3x) - (WIDE_W'(r1_m23y) >>> 16));
            r2_p23y <= sat_mid(WIDE_W'(r_e3y) + (WIDE_W'(r1_m23x) >>> 16));

            r3_bad  <= w3_side[SIDE_W-1];
            r3_mx   <= 64'(w3_c31) * 64'(r_sy);
            r3_my   <= 64'(w3_c31) * 64'(r_sx);
            r3_mk   <= 63'(w3_c31) * 63'(r_cr);
            r3_p12x <= w3_side[4*MID_W-1 -: MID_W];
            r3_p12y <= w3_side[3*MID_W-1 -: MID_W];
            r3_p23x <= w3_side[2*MID_W-1 -: MID_W];
            r3_p23y <= w3_side[MID_W-1:0];

            r4_bad  <= r3_bad;
            r4_p31x <= sat_mid(WIDE_W'(r_ssx) + (WIDE_W'(r3_mx) >>> 16));
            r4_p31y <= sat_mid(WIDE_W'(r_ssy) - (WIDE_W'(r3_my) >>> 16));
            r4_k31  <= sat_mid(WIDE_W'(r_dot) + (WIDE_W'(r3_mk) >>> 16));
            r4_p12x <= r3_p12x;
            r4_p12y <= r3_p12y;
            r4_p23x <= r3_p23x;
            r4_p23y <= r3_p23y;

            r5_bad  <= r4_bad;
            r5_dxa  <= sat_mid(WIDE_W'(r4_p12x) - WIDE_W'(r4_p23x));
            r5_dya  <= sat_mid(WIDE_W'(r4_p23y) - WIDE_W'(r4_p31y));
            r5_dyb  <= sat_mid(WIDE_W'(r4_p12y) - WIDE_W'(r4_p23y));
            r5_dxb  <= sat_mid(WIDE_W'(r4_p23x) - WIDE_W'(r4_p31x));
            r5_k31  <= r4_k31;

            r6_bad  <= r5_bad;
            r6_pa   <= (2*MID_W)'(r5_dxa) * (2*MID_W)'(r5_dya);
            r6_pb   <= (2*MID_W)'(r5_dyb) * (2*MID_W)'(r5_dxb);
            r6_nx   <= (2*MID_W)'(r5_k31) * (2*MID_W)'(r5_dyb);
            r6_ny   <= (2*MID_W)'(r5_k31) * (2*MID_W)'(-r5_dxa);

            r7_bad  <= r6_bad || ((n7_adj >>> 12) == '0);
            r7_dd   <= DD_W'(n7_adj >>> 12);
            r7_nx   <= r6_nx;
            r7_ny   <= r6_ny;

            r8_bad  <= w8_badx || w8_bady;
            r8_rx   <= (w8_badx || w8_bady) ? '0 : out_sat(n8_sx);
            r8_ry   <= (w8_badx || w8_bady) ? '0 : out_sat(n8_sy);
        end
    end

    tbt_div #(
        .NUM_W  (C31_NUM_W),
        .DEN_W  (C31_DEN_W),
        .SIDE_W (SIDE_W)
    ) u_div_c31 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r2_vld),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  ({r2_bad, r2_p12x, r2_p12y, r2_p23x, r2_p23y}),
        .o_vld   (w3_vld),
        .o_quo   (w3_quo),
        .o_side  (w3_side)
    );

    tbt_div #(
        .NUM_W  (OFS_NUM_W),
        .DEN_W  (DD_W),
        .SIDE_W (1)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r7_vld),
        .i_num   (r7_nx),
        .i_den   (r7_dd),
        .i_side  (r7_bad),
        .o_vld   (w8_vldx),
        .o_quo   (w8_qx),
        .o_side  (w8_badx)
    );

    tbt_div #(
        .NUM_W  (OFS_NUM_W),
        .DEN_W  (DD_W),
        .SIDE_W (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r7_vld),
        .i_num   (r7_ny),
        .i_den   (r7_dd),
        .i_side  (r7_bad),
        .o_vld   (w8_vldy),
        .o_quo   (w8_qy),
        .o_side  (w8_bady)
    );

    assign o_vld = r8_vld;
    assign o_bad = r8_bad;
    assign o_rx  = r8_rx;
    assign o_ry  = r8_ry;

endmodule

@@ src/three_beacon_triangulation.sv @@
// Top level of the three-beacon triangulation block.
// Finds the robot's world position from the sensor-frame positions of three beacons whose
// world positions sit in six configuration registers (index 0..5: first beacon x, y, second
// beacon x, y, third beacon x, y; signed Q8.12, reset 0; other indexes are dropped). Three
// bearing lanes take atan2 of each sighting with a pipelined CORDIC, two cotangent lanes turn
// the bearing differences into cotangents, and a merge stage applies the three-object method
// relative to the second beacon. One request is taken every cycle unless a result waits on
// the output, when the whole pipeline holds. Each request passes through a bearing CORDIC
// pipeline, a cotangent CORDIC pipeline and three bit-per-cycle dividers (cotangent, third
// cotangent, offsets). When a bearing difference is zero modulo pi, the cotangent sum is zero
// or the determinant is zero, the result carries the degenerate flag with zero coordinates;
// coordinates otherwise saturate to the field range.
module three_beacon_triangulation #(
    parameter int COORD_WIDTH  = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Request stream
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // seen_a_x, seen_a_y, seen_b_x, seen_b_y, seen_c_x, seen_c_y
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // Result stream
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // robot_x, robot_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       o_m_tdata,
    // degenerate
    output logic [0:0]                               o_m_tuser,
    // Register writes
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [tbt_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                   i_cfg_data
);
    import tbt_pkg::*;

    localparam int OUT_W = ((2*COORD_WIDTH+7)/8)*8;

    logic signed [COORD_WIDTH-1:0] r_bax, r_bay, r_bbx, r_bby, r_bcx, r_bcy;

    logic     w_en;
    logic     w_bvld [0:2];
    t_ang     w_ang  [0:2];
    t_cot_res w_cot  [0:1];
    logic     w_vld, w_bad;
    logic signed [COORD_WIDTH-1:0] w_rx, w_ry;

    // Advance everything unless a finished result is waiting
    assign w_en        = !w_vld || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bax <= '0;
            r_bay <= '0;
            r_bbx <= '0;
            r_bby <= '0;
            r_bcx <= '0;
            r_bcy <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BAX: r_bax <= i_cfg_data;
                CFG_BAY: r_bay <= i_cfg_data;
                CFG_BBX: r_bbx <= i_cfg_data;
                CFG_BBY: r_bby <= i_cfg_data;
                CFG_BCX: r_bcx <= i_cfg_data;
                CFG_BCY: r_bcy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bearing lanes, one per beacon
    for (genvar g = 0; g < 3; g++) begin : g_bearing
        tbt_vcordic #(
            .COORD_WIDTH  (COORD_WIDTH),
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_bearing (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (i_s_tvalid),
            .i_x     ($signed(i_s_tdata[2*g*COORD_WIDTH +: COORD_WIDTH])),
            .i_y     ($signed(i_s_tdata[(2*g+1)*COORD_WIDTH +: COORD_WIDTH])),
            .o_vld   (w_bvld[g]),
            .o_ang   (w_ang[g])
        );
    end

    // Cotangent lanes: first-to-second and second-to-third bearing
    for (genvar g = 0; g < 2; g++) begin : g_cot
        tbt_cot #(
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_cot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_bvld[g] && w_bvld[g+1]),
            .i_from  (w_ang[g]),
            .i_to    (w_ang[g+1]),
            .o_res   (w_cot[g])
        );
    end

    // Merge stage; its last register is the output register
    tbt_solve #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_c12   (w_cot[0]),
        .i_c23   (w_cot[1]),
        .i_bax   (r_bax),
        .i_bay   (r_bay),
        .i_bbx   (r_bbx),
        .i_bby   (r_bby),
        .i_bcx   (r_bcx),
        .i_bcy   (r_bcy),
        .o_vld   (w_vld),
        .o_bad   (w_bad),
        .o_rx    (w_rx),
        .o_ry    (w_ry)
    );

    assign o_m_tvalid   = w_vld;
    assign o_m_tdata    = OUT_W'({w_ry, w_rx});
    assign o_m_tuser[0] = w_bad;

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("degenerate result with non-zero coordinates");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while result stalled");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == CFG_BBX)) |=> (r_bbx == $past(i_cfg_data)))
        else $error("reference beacon x not written");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the three-beacon triangulation block.
`timescale 1ns / 100ps

module tb;
    import tbt_pkg::*;

    localparam int CW         = 20;
    localparam int STEPS      = 16;
    localparam int LATENCY    = 2*STEPS + 188;
    localparam int IN_W       = ((6*CW+7)/8)*8;
    localparam int OUT_W      = ((2*CW+7)/8)*8;
    localparam longint COORD_MAX = (64'sd1 <<< (CW-1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (CW-1));
    // Index past the register file; the block must drop the write
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST = 3'd7;

    typedef logic signed [CW-1:0] t_coord;

    // One sighting request: three beacons in the sensor frame
    typedef struct {
        t_coord ax, ay, bx, by, cx, cy;
    } t_sight;

    // One position fix
    typedef struct {
        t_coord x;
        t_coord y;
        logic   degen;
    } t_fix;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;
    logic [0:0]       o_m_tuser;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CW-1:0]    i_cfg_data;

    three_beacon_triangulation #(
        .COORD_WIDTH (CW),
        .CORDIC_STEPS(STEPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    t_sight sight_q[$];     // requests waiting for the driver
    t_fix   fix_q[$];       // fixes predicted but not yet seen
    t_coord beacon_w[6];    // mirror of the beacon registers
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_send;
    bit     req_taken;
    int     mismatches;

    // ---------------------------------------------------------------- predictor

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;     // arithmetic shift on a signed value rounds to minus infinity
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Vectoring CORDIC atan2, angle in units of 2^-24 rad
    function automatic longint sight_bearing(input longint px, input longint py);
        longint x, y, z, nx, ny;
        x = px * 1024;
        y = py * 1024;
        z = 0;
        if (px == 0 && py == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            if (y < 0) begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z  = z - longint'(ATAN_TAB[i]);
            end else begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z  = z + longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Cotangent of a bearing difference in Q.16; returns 0 when it does not exist
    function automatic bit bearing_cot(input longint diff, output longint cot);
        longint x, y, d, nx, ny;
        x   = 64'sd268435456;
        y   = 0;
        d   = diff;
        cot = 0;
        while (d > longint'(ANG_HALF_PI)) d = d - longint'(ANG_PI);
        while (d <= -longint'(ANG_HALF_PI)) d = d + longint'(ANG_PI);
        if (d == 0) return 0;
        for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
            if (d >= 0) begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                d  = d - longint'(ATAN_TAB[i]);
            end else begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                d  = d + longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        if (y == 0) return 0;
        cot = clamp((x * 65536) / y, COT_LIM);
        return 1;
    endfunction

    // Three-object fix relative to the second beacon
    function automatic t_fix triangulate(input t_sight s);
        t_fix   f;
        longint bax, bay, bbx, bby, bcx, bcy;
        longint a1, a2, a3, c12, c23, c31, den;
        longint e1x, e1y, e3x, e3y, p12x, p12y, p23x, p23y, p31x, p31y;
        longint cr, k31, dxa, dya, dyb, dxb, dd;
        f.x = '0;
        f.y = '0;
        f.degen = 1'b1;
        bax = beacon_w[CFG_BAX]; bay = beacon_w[CFG_BAY];
        bbx = beacon_w[CFG_BBX]; bby = beacon_w[CFG_BBY];
        bcx = beacon_w[CFG_BCX]; bcy = beacon_w[CFG_BCY];
        a1 = sight_bearing(s.ax, s.ay);
        a2 = sight_bearing(s.bx, s.by);
        a3 = sight_bearing(s.cx, s.cy);
        if (!bearing_cot(a2 - a1, c12)) return f;
        if (!bearing_cot(a3 - a2, c23)) return f;
        den = c12 + c23;
        if (den == 0) return f;
        c31 = clamp(((64'sd1 <<< 32) - c12 * c23) / den, COT_LIM);

        e1x = clamp(bax - bbx, MID_LIM);
        e1y = clamp(bay - bby, MID_LIM);
        e3x = clamp(bcx - bbx, MID_LIM);
        e3y = clamp(bcy - bby, MID_LIM);

        p12x = clamp(e1x + floor_shr(c12 * e1y, 16), MID_LIM);
        p12y = clamp(e1y - floor_shr(c12 * e1x, 16), MID_LIM);
        p23x = clamp(e3x - floor_shr(c23 * e3y, 16), MID_LIM);
        p23y = clamp(e3y + floor_shr(c23 * e3x, 16), MID_LIM);
        p31x = clamp(e3x + e1x + floor_shr(c31 * (e3y - e1y), 16), MID_LIM);
        p31y = clamp(e3y + e1y - floor_shr(c31 * (e3x - e1x), 16), MID_LIM);

        cr  = clamp(floor_shr(e1x * e3y - e3x * e1y, 12), MID_LIM);
        k31 = clamp(floor_shr(e1x * e3x + e1y * e3y, 12) + floor_shr(c31 * cr, 16), MID_LIM);

        dxa = clamp(p12x - p23x, MID_LIM);
        dya = clamp(p23y - p31y, MID_LIM);
        dyb = clamp(p12y - p23y, MID_LIM);
        dxb = clamp(p23x - p31x, MID_LIM);
        dd  = (dxa * dya - dyb * dxb) / 4096;
        if (dd == 0) return f;

        f.x = t_coord'(clamp_coord(bbx + clamp((k31 * dyb) / dd, OFF_LIM)));
        f.y = t_coord'(clamp_coord(bby + clamp((k31 * -dxa) / dd, OFF_LIM)));
        f.degen = 1'b0;
        return f;
    endfunction

    // ---------------------------------------------------------------- clock, driver, monitor

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Present requests on the falling edge; hold one until it has been taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !req_taken) begin
            // hold the current request
        end else if (!hold_send && sight_q.size() > 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            t_sight s;
            s = sight_q.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {s.cy, s.cx, s.by, s.bx, s.ay, s.ax};
        end else begin
            i_s_tvalid <= 1'b0;
        end
        i_m_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample on the rising edge: predict on each accepted request, check each result
    always @(posedge i_clk) begin
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < CFG_NONE)
                beacon_w[i_cfg_index] = i_cfg_data;
            if (i_s_tvalid && o_s_tready) begin
                t_sight s;
                t_fix   p;
                req_taken = 1'b1;
                {s.cy, s.cx, s.by, s.bx, s.ay, s.ax} = i_s_tdata;
                p = triangulate(s);
                fix_q = {fix_q, p};
            end
            if (o_m_tvalid && i_m_tready) begin
                t_fix want, got;
                got.x     = o_m_tdata[CW-1:0];
                got.y     = o_m_tdata[2*CW-1:CW];
                got.degen = o_m_tuser[0];
                if (fix_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result x=%0d y=%0d degenerate=%0b",
                                 $realtime, got.x, got.y, got.degen);
                end else begin
                    want = fix_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.degen !== want.degen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: want x=%0d y=%0d dg=%0b, got x=%0d y=%0d dg=%0b",
                                     $realtime, want.x, want.y, want.degen,
                                     got.x, got.y, got.degen);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic write_beacon(input logic [CFG_IDX_W-1:0] idx, input t_coord val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic place_beacons(input t_coord ax, ay, bx, by, cx, cy);
        write_beacon(CFG_BAX, ax);
        write_beacon(CFG_BAY, ay);
        write_beacon(CFG_BBX, bx);
        write_beacon(CFG_BBY, by);
        write_beacon(CFG_BCX, cx);
        write_beacon(CFG_BCY, cy);
    endtask

    // Wait until every request has gone in and every fix has come out
    task automatic drain();
        do @(posedge i_clk); while (sight_q.size() > 0 || i_s_tvalid || fix_q.size() > 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(9))
            0:       return t_coord'(COORD_MAX);
            1:       return t_coord'(COORD_MIN);
            2, 3:    return t_coord'($urandom);
            default: return t_coord'($signed($urandom_range(40000)) - 20000);
        endcase
    endfunction

    task automatic queue_sight(input t_coord ax, ay, bx, by, cx, cy);
        t_sight s;
        s.ax = ax; s.ay = ay; s.bx = bx; s.by = by; s.cx = cx; s.cy = cy;
        sight_q = {sight_q, s};
    endtask

    // Mostly plausible sightings: beacons spread round the sensor, with some noise
    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 7)
                queue_sight(t_coord'($signed($urandom_range(16000)) + 4000),
                            t_coord'($signed($urandom_range(8000)) - 4000),
                            t_coord'($signed($urandom_range(16000)) - 20000),
                            t_coord'($signed($urandom_range(16000)) + 4000),
                            t_coord'($signed($urandom_range(16000)) - 20000),
                            t_coord'($signed($urandom_range(16000)) - 20000));
            else
                queue_sight(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_BAX;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_send      = 1'b0;
        req_taken      = 1'b0;
        mismatches     = 0;
        foreach (beacon_w[i]) beacon_w[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: every beacon at the origin, so every fix is degenerate
        queue_sight(20'sd4096, 20'sd0, 20'sd0, 20'sd4096, -20'sd4096, 20'sd0);
        drain();

        // Directed: a square of beacons, then the edge cases
        place_beacons(20'sd8192, 20'sd0, 20'sd0, 20'sd8192, -20'sd8192, 20'sd0);
        write_beacon(CFG_NONE, 20'sd12345);
        write_beacon(CFG_LAST, -20'sd1);
        queue_sight(20'sd4096, -20'sd4096, 20'sd4096, 20'sd4096, -20'sd4096, 20'sd4096);
        queue_sight(20'sd6000, 20'sd1000, -20'sd2000, 20'sd7000, -20'sd5000, -20'sd3000);
        queue_sight(20'sd0, 20'sd0, 20'sd4096, 20'sd4096, -20'sd4096, 20'sd4096);
        queue_sight(20'sd4096, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd4096);
        queue_sight(20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0);
        // same bearing twice, and bearings pi apart
        queue_sight(20'sd4096, 20'sd4096, 20'sd8192, 20'sd8192, -20'sd4096, 20'sd0);
        queue_sight(20'sd4096, 20'sd0, -20'sd4096, 20'sd0, 20'sd0, 20'sd4096);
        queue_sight(20'sd0, 20'sd4096, 20'sd4096, 20'sd0, 20'sd0, -20'sd4096);
        queue_sight(t_coord'(COORD_MAX), t_coord'(COORD_MAX), t_coord'(COORD_MIN),
                    t_coord'(COORD_MAX), t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        queue_sight(t_coord'(COORD_MIN), t_coord'(COORD_MIN), t_coord'(COORD_MIN),
                    t_coord'(COORD_MIN), t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        queue_sight(t_coord'(COORD_MAX), t_coord'(COORD_MIN), t_coord'(COORD_MIN),
                    t_coord'(COORD_MIN), t_coord'(COORD_MAX), t_coord'(COORD_MAX));
        queue_sight(-20'sd1, 20'sd0, 20'sd0, -20'sd1, 20'sd1, 20'sd1);
        queue_sight(t_coord'(COORD_MAX), 20'sd1, 20'sd1, t_coord'(COORD_MAX),
                    t_coord'(COORD_MIN), 20'sd1);
        drain();

        // Phase: no idling
        queue_random(150);
        drain();

        // Phase: beacons at the far corners, sender mostly idle
        place_beacons(t_coord'(COORD_MAX), t_coord'(COORD_MAX), t_coord'(COORD_MIN),
                      t_coord'(COORD_MIN), t_coord'(COORD_MAX), t_coord'(COORD_MIN));
        send_idle_pct = 85;
        queue_random(150);
        drain();

        // Phase: random beacons, receiver mostly stalling; pause midway until all is back
        place_beacons(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        queue_random(75);
        do @(posedge i_clk); while (sight_q.size() > 0 || i_s_tvalid);
        hold_send = 1'b1;
        do @(posedge i_clk); while (fix_q.size() > 0);
        hold_send = 1'b0;
        queue_random(75);
        drain();

        // Phase: opposite extremes, both sides idling
        place_beacons(t_coord'(COORD_MIN), t_coord'(COORD_MAX), t_coord'(COORD_MAX),
                      t_coord'(COORD_MIN), t_coord'(COORD_MIN), t_coord'(COORD_MIN));
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random(150);
        drain();

        // Phase: realistic arena, no idling
        place_beacons(20'sd0, 20'sd40960, 20'sd12288, -20'sd4096, -20'sd12288, -20'sd4096);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(150);
        drain();

        // Phase: same arena, both sides idling
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random(150);
        drain();

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
